// File: design/tra_pkg.sv
// Shared widths, register indexes and the datapath command bundle for the
// tare and running average core. No dependencies.
`timescale 1ns / 1ps

package tra_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int ACC_W      = 40;
    localparam int DEPTH_W    = 8;
    localparam int CNT_W      = 8;
    localparam int MEAN_SHIFT = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // one quotient bit per step, dividend is the full accumulator width
    localparam int DIV_STEPS  = ACC_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] COUNT_LIMIT = {CNT_W{1'b1}};

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_TARE_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_B    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_DEPTH = 2'd2;

    typedef struct packed {
        logic load;    // capture the input item
        logic prep;    // net, counts, divisor; start both dividers
        logic step;    // one divider iteration
        logic update;  // form and store the new accumulator
        logic commit;  // load the output register
    } t_dp_cmd;

endpackage

// File: design/tra_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per step,
// truncating toward zero. Uses tra_pkg.
`timescale 1ns / 1ps

module tra_div (
    input  logic                             i_clk,
    input  logic                             i_load,
    input  logic                             i_step,
    input  logic signed [tra_pkg::ACC_W-1:0] i_dividend,
    input  logic        [tra_pkg::DEPTH_W-1:0] i_divisor,
    output logic signed [tra_pkg::ACC_W-1:0] o_quotient
);
    import tra_pkg::*;

    logic [ACC_W-1:0]   r_q;
    logic [DEPTH_W-1:0] r_rem;
    logic [DEPTH_W-1:0] r_div;
    logic               r_neg;

    logic [DEPTH_W:0]   w_trial;
    logic               w_fit;

    assign w_trial = {r_rem, r_q[ACC_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_neg <= i_dividend[ACC_W-1];
            r_q   <= i_dividend[ACC_W-1] ? ACC_W'(-i_dividend) : i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (i_step) begin
            // remainder stays below the divisor, so it fits DEPTH_W bits
            r_rem <= w_fit ? DEPTH_W'(w_trial - {1'b0, r_div}) : w_trial[DEPTH_W-1:0];
            r_q   <= {r_q[ACC_W-2:0], w_fit};
        end
    end

    assign o_quotient = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

// File: design/tra_ctrl.sv
// Sequencer for the tare and running average core: handshakes, divider
// step count and datapath commands. Uses tra_pkg.
`timescale 1ns / 1ps

module tra_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tra_pkg::t_dp_cmd  o_cmd
);
    import tra_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_UPDATE,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [STEP_CNT_W-1:0] r_step_cnt;
    logic                  r_out_valid;
    logic                  w_out_free;

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;

    assign o_cmd.load   = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.prep   = (r_state == S_PREP);
    assign o_cmd.step   = (r_state == S_DIV);
    assign o_cmd.update = (r_state == S_UPDATE);
    assign o_cmd.commit = (r_state == S_DONE) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_step_cnt <= '0;
                    r_state    <= S_DIV;
                end
                S_DIV: begin
                    if (r_step_cnt == STEP_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_UPDATE;
                    end else begin
                        r_step_cnt <= r_step_cnt + 1'b1;
                    end
                end
                S_UPDATE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/tra_datapath.sv
// Datapath: config registers, per-channel counts and accumulators, net
// value, two dividers and the output register. Uses tra_pkg, tra_div.
`timescale 1ns / 1ps

module tra_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tra_pkg::t_dp_cmd                      i_cmd,
    input  logic                                  i_cfg_we,
    input  logic        [tra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [tra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                                  i_sensor_channel,
    input  logic signed [tra_pkg::SAMPLE_W-1:0]   i_raw_sample,
    input  logic                                  i_restart,
    output logic                                  o_out_channel,
    output logic signed [tra_pkg::SAMPLE_W-1:0]   o_net_value,
    output logic signed [tra_pkg::SAMPLE_W-1:0]   o_average_value
);
    import tra_pkg::*;

    logic signed [SAMPLE_W-1:0] r_tare_a;
    logic signed [SAMPLE_W-1:0] r_tare_b;
    logic        [DEPTH_W-1:0]  r_depth;
    logic        [CNT_W-1:0]    r_count [2];
    logic signed [ACC_W-1:0]    r_acc   [2];

    logic                       r_ch;
    logic signed [SAMPLE_W-1:0] r_raw;
    logic                       r_restart;
    logic signed [SAMPLE_W-1:0] r_net;
    logic signed [ACC_W-1:0]    r_acc_new;

    logic                       r_out_ch;
    logic signed [SAMPLE_W-1:0] r_out_net;
    logic signed [SAMPLE_W-1:0] r_out_avg;

    logic signed [SAMPLE_W-1:0] w_tare;
    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [SAMPLE_W-1:0] w_net;
    logic        [CNT_W-1:0]    w_base [2];
    logic        [CNT_W-1:0]    w_cnt_next;
    logic        [DEPTH_W-1:0]  w_d;
    logic signed [ACC_W-1:0]    w_scaled;
    logic signed [ACC_W-1:0]    w_q_acc;
    logic signed [ACC_W-1:0]    w_q_net;
    logic signed [ACC_W-1:0]    w_acc_sum;
    logic        [ACC_W-1:0]    w_biased;
    logic        [ACC_W-MEAN_SHIFT-1:0] w_avg_wide;
    logic        [ACC_W-MEAN_SHIFT-SAMPLE_W:0] w_avg_top;
    logic signed [SAMPLE_W-1:0] w_avg;

    // net value, clamped to the sample range
    assign w_tare = r_ch ? r_tare_b : r_tare_a;
    assign w_diff = {r_raw[SAMPLE_W-1], r_raw} - {w_tare[SAMPLE_W-1], w_tare};

    always_comb begin
        if (w_diff[SAMPLE_W] != w_diff[SAMPLE_W-1]) begin
            w_net = w_diff[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
            w_net = w_diff[SAMPLE_W-1:0];
        end
    end

    // restart clears both counts before this sample counts
    assign w_base[0]  = r_restart ? '0 : r_count[0];
    assign w_base[1]  = r_restart ? '0 : r_count[1];
    assign w_cnt_next = (w_base[r_ch] == COUNT_LIMIT) ? COUNT_LIMIT : w_base[r_ch] + 1'b1;
    assign w_d        = (r_depth < w_cnt_next) ? r_depth : w_cnt_next;

    assign w_scaled = {{(ACC_W-SAMPLE_W-MEAN_SHIFT){w_net[SAMPLE_W-1]}}, w_net,
                       {MEAN_SHIFT{1'b0}}};

    tra_div u_div_acc (
        .i_clk      (i_clk),
        .i_load     (i_cmd.prep),
        .i_step     (i_cmd.step),
        .i_dividend (r_acc[r_ch]),
        .i_divisor  (w_d),
        .o_quotient (w_q_acc)
    );

    tra_div u_div_net (
        .i_clk      (i_clk),
        .i_load     (i_cmd.prep),
        .i_step     (i_cmd.step),
        .i_dividend (w_scaled),
        .i_divisor  (w_d),
        .o_quotient (w_q_net)
    );

    assign w_acc_sum = r_acc[r_ch] - w_q_acc + w_q_net;

    // acc/256 toward zero: bias negative values by 255 before the shift
    assign w_biased   = r_acc_new + {{(ACC_W-MEAN_SHIFT){1'b0}},
                                     {MEAN_SHIFT{r_acc_new[ACC_W-1]}}};
    assign w_avg_wide = w_biased[ACC_W-1:MEAN_SHIFT];
    assign w_avg_top  = w_avg_wide[ACC_W-MEAN_SHIFT-1:SAMPLE_W-1];

    always_comb begin
        if ((&w_avg_top) || !(|w_avg_top)) begin
            w_avg = w_avg_wide[SAMPLE_W-1:0];
        end else begin
            w_avg = w_avg_top[ACC_W-MEAN_SHIFT-SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tare_a <= '0;
            r_tare_b <= '0;
            r_depth  <= '0;
            for (int i = 0; i < 2; i++) begin
                r_count[i] <= '0;
                r_acc[i]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TARE_A:    r_tare_a <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_TARE_B:    r_tare_b <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_AVG_DEPTH: r_depth  <= i_cfg_data[DEPTH_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.prep) begin
                for (int i = 0; i < 2; i++) begin
                    r_count[i] <= (r_ch == 1'(i)) ? w_cnt_next : w_base[i];
                end
            end
            if (i_cmd.update && (r_depth != '0)) begin
                r_acc[r_ch] <= w_acc_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch      <= i_sensor_channel;
            r_raw     <= i_raw_sample;
            r_restart <= i_restart;
        end
        if (i_cmd.prep) begin
            r_net <= w_net;
        end
        if (i_cmd.update) begin
            // depth zero leaves the average frozen
            r_acc_new <= (r_depth != '0) ? w_acc_sum : r_acc[r_ch];
        end
        if (i_cmd.commit) begin
            r_out_ch  <= r_ch;
            r_out_net <= r_net;
            r_out_avg <= w_avg;
        end
    end

    assign o_out_channel   = r_out_ch;
    assign o_net_value     = r_out_net;
    assign o_average_value = r_out_avg;

endmodule

// File: design/tare_and_running_average_core.sv
// Tare and running average core, top level. Each input transfer passes through the
// prep, divider, update and done states before output valid, one quotient bit per
// cycle over 40 bits in the bit-serial dividers; a new item is taken only back in idle,
// and a waiting result stalls completion only. Config writes are always accepted.
// Synchronous active-low reset clears tares, depth, counts and accumulators.
// Uses tra_pkg, tra_ctrl, tra_datapath.
`timescale 1ns / 1ps

module tare_and_running_average_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [tra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [tra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_sensor_channel,
    input  logic signed [tra_pkg::SAMPLE_W-1:0]   i_raw_sample,
    input  logic                                  i_restart,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_out_channel,
    output logic signed [tra_pkg::SAMPLE_W-1:0]   o_net_value,
    output logic signed [tra_pkg::SAMPLE_W-1:0]   o_average_value
);
    import tra_pkg::*;

    t_dp_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    tra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    tra_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_sensor_channel (i_sensor_channel),
        .i_raw_sample     (i_raw_sample),
        .i_restart        (i_restart),
        .o_out_channel    (o_out_channel),
        .o_net_value      (o_net_value),
        .o_average_value  (o_average_value)
    );

endmodule

// File: design/tra_checker.sv
// Port-level checker for the tare and running average core, with its bind.
// Uses tra_pkg.
`timescale 1ns / 1ps

module tra_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  o_in_ready,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    input  logic                                  o_out_channel,
    input  logic signed [tra_pkg::SAMPLE_W-1:0]   o_net_value,
    input  logic signed [tra_pkg::SAMPLE_W-1:0]   o_average_value
);
    import tra_pkg::*;

    logic [1:0] r_pend;
    logic       w_in_xfer;
    logic       w_out_xfer;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = o_out_valid && i_out_ready;

    // items accepted whose result has not been transferred yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(w_in_xfer) - 2'(w_out_xfer);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_channel)
            && $stable(o_net_value) && $stable(o_average_value))
        else $error("output dropped or changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer |-> r_pend != 2'd0)
        else $error("result transferred without a pending item");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 2'd2)
        else $error("more than two items in flight");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_in_ready && !(o_out_valid && !$past(o_out_valid)))
        else $error("input ready or new result right after an input transfer");

endmodule

bind tare_and_running_average_core tra_checker u_tra_checker (.*);

// File: dv/tare_and_running_average_core_tb.sv
// Self-checking testbench for tare_and_running_average_core: directed and random load-cell
// samples, an in-bench predictor of the tare, count and running average, random stalls.
// Depends on tra_pkg and the core RTL only.
`timescale 1ns / 1ps

module tare_and_running_average_core_tb;

    import tra_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SETTLE_CYCLES = 60;   // beyond the core's input-to-output latency
    localparam longint      MEAN_SCALE = 256;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int { IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE } t_idle_mode;

    typedef struct packed {
        logic                       ch;
        logic signed [SAMPLE_W-1:0] raw;
        logic                       restart;
    } t_sample;

    typedef struct packed {
        logic                       ch;
        logic signed [SAMPLE_W-1:0] net;
        logic signed [SAMPLE_W-1:0] avg;
    } t_reading;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic                        i_sensor_channel = 1'b0;
    logic signed [SAMPLE_W-1:0]  i_raw_sample = '0;
    logic                        i_restart = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic                        o_out_channel;
    logic signed [SAMPLE_W-1:0]  o_net_value;
    logic signed [SAMPLE_W-1:0]  o_average_value;

    tare_and_running_average_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sensor_channel (i_sensor_channel),
        .i_raw_sample     (i_raw_sample),
        .i_restart        (i_restart),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_channel    (o_out_channel),
        .o_net_value      (o_net_value),
        .o_average_value  (o_average_value)
    );

    always #2 i_clk = ~i_clk;

    // predictor state and its copy of the registers
    logic signed [SAMPLE_W-1:0] tare_a_reg = '0;
    logic signed [SAMPLE_W-1:0] tare_b_reg = '0;
    logic [DEPTH_W-1:0]         depth_reg = '0;
    logic [CNT_W-1:0]           sample_cnt [2] = '{default: '0};
    logic signed [ACC_W-1:0]    mean_acc [2] = '{default: '0};

    t_sample    pending_samples [$];
    t_reading   expected_readings [$];
    t_idle_mode idle_mode = IDLE_SEND_LIGHT;
    int         cycle_count = 0;
    int         error_count = 0;
    int         readings_checked = 0;
    int         settings_used = 0;

    function automatic logic signed [SAMPLE_W-1:0] clamp_sample(longint v);
        if (v > longint'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (v < longint'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic t_reading weigh_sample(t_sample s);
        longint   tare;
        longint   net;
        longint   acc;
        longint   d;
        t_reading r;
        tare = s.ch ? longint'(tare_b_reg) : longint'(tare_a_reg);
        net = longint'(clamp_sample(longint'(s.raw) - tare));
        if (s.restart) begin
            sample_cnt[0] = '0;
            sample_cnt[1] = '0;
        end
        if (sample_cnt[s.ch] != COUNT_LIMIT)
            sample_cnt[s.ch] = sample_cnt[s.ch] + 1'b1;
        acc = longint'(mean_acc[s.ch]);
        if (depth_reg != 0) begin
            d = longint'(depth_reg);
            if (longint'(sample_cnt[s.ch]) < d)
                d = longint'(sample_cnt[s.ch]);
            acc = acc - acc / d;
            acc = acc + (net * MEAN_SCALE) / d;
            mean_acc[s.ch] = acc[ACC_W-1:0];
            acc = longint'(mean_acc[s.ch]);
        end
        r.ch = s.ch;
        r.net = net[SAMPLE_W-1:0];
        r.avg = clamp_sample(acc / MEAN_SCALE);
        return r;
    endfunction

    function automatic bit idle_hit(int pct);
        return $urandom_range(99) < pct;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // sample source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin : drive_samples
            t_sample s;
            int      gap_pct;
            if (i_in_valid && o_in_ready)
                expected_readings.push_back(weigh_sample({i_sensor_channel, i_raw_sample,
                                                          i_restart}));
            gap_pct = (idle_mode == IDLE_SEND_LIGHT) ? 11 :
                      (idle_mode == IDLE_SEND_HEAVY) ? 46 : 0;
            if (!i_in_valid || o_in_ready) begin
                if (pending_samples.size() != 0 && !idle_hit(gap_pct)) begin
                    s = pending_samples.pop_front();
                    i_sensor_channel <= s.ch;
                    i_raw_sample     <= s.raw;
                    i_restart        <= s.restart;
                    i_in_valid       <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin : check_readings
            t_reading want;
            int       stall_pct;
            if (o_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("result with no sample outstanding");
                end else begin
                    want = expected_readings.pop_front();
                    if (o_out_channel !== want.ch)
                        report_mismatch($sformatf("channel got %0d expected %0d",
                                                  o_out_channel, want.ch));
                    if (o_net_value !== want.net)
                        report_mismatch($sformatf("net got %0d expected %0d",
                                                  o_net_value, want.net));
                    if (o_average_value !== want.avg)
                        report_mismatch($sformatf("average got %0d expected %0d",
                                                  o_average_value, want.avg));
                end
                readings_checked++;
            end
            stall_pct = (idle_mode == IDLE_SEND_LIGHT) ? 46 :
                        (idle_mode == IDLE_SEND_HEAVY) ? 11 : 0;
            i_out_ready <= !idle_hit(stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TARE_A:    tare_a_reg = data;
            CFG_TARE_B:    tare_b_reg = data;
            CFG_AVG_DEPTH: depth_reg = data[DEPTH_W-1:0];
            default:       ;
        endcase
    endtask

    // wait until every queued sample has come back, then let the core go quiet
    task automatic drain_core();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || i_in_valid || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] tare_a,
                                 input logic [CFG_DATA_W-1:0] tare_b,
                                 input logic [CFG_DATA_W-1:0] depth);
        drain_core();
        write_reg(CFG_TARE_A, tare_a);
        write_reg(CFG_TARE_B, tare_b);
        write_reg(CFG_AVG_DEPTH, depth);
        settings_used++;
        @(negedge i_clk);
    endtask

    task automatic add_sample(input logic ch, input logic signed [SAMPLE_W-1:0] raw,
                              input logic restart);
        pending_samples.push_back({ch, raw, restart});
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_reading();
        case ($urandom_range(15))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return '1;
            4, 5:    return SAMPLE_W'($signed($urandom_range(2000)) - 1000);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // restart_per_k: chance per thousand that a sample clears both counts
    task automatic add_random(input int n, input int restart_per_k);
        repeat (n)
            add_sample(1'($urandom_range(1)), random_reading(),
                       $urandom_range(999) < restart_per_k);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: depth zero keeps the average at zero
        add_sample(1'b0, SAMPLE_MAX, 1'b0);
        add_sample(1'b1, SAMPLE_MIN, 1'b0);
        add_sample(1'b0, '0, 1'b1);

        // extreme tares push the net into both rails; depth one follows the net
        load_settings(SAMPLE_MAX, SAMPLE_MIN, 24'd1);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
        @(negedge i_clk);
        add_sample(1'b0, SAMPLE_MIN, 1'b0);
        add_sample(1'b1, SAMPLE_MAX, 1'b0);
        add_sample(1'b0, SAMPLE_MAX, 1'b0);
        add_sample(1'b1, SAMPLE_MIN, 1'b0);
        add_sample(1'b0, '1, 1'b1);

        load_settings('0, '0, 24'd255);
        add_sample(1'b0, SAMPLE_MAX, 1'b1);
        add_sample(1'b0, SAMPLE_MAX, 1'b0);
        add_sample(1'b0, SAMPLE_MIN, 1'b0);
        add_sample(1'b1, SAMPLE_MIN, 1'b0);
        add_sample(1'b1, 24'sd12345, 1'b0);
        add_sample(1'b0, '0, 1'b0);

        // depth zero over a loaded accumulator, then upper data bits ignored
        load_settings('0, '0, '0);
        add_sample(1'b0, 24'sd100, 1'b0);
        add_sample(1'b1, -24'sd100, 1'b0);
        load_settings(24'sd5, -24'sd5, 24'hFFFF03);
        add_sample(1'b0, SAMPLE_MAX, 1'b1);
        add_sample(1'b0, SAMPLE_MIN, 1'b0);
        add_sample(1'b1, 24'sd7, 1'b0);

        // long run without restarts so both counts saturate
        load_settings(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), 24'd255);
        add_random(600, 0);
        load_settings(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                      CFG_DATA_W'($urandom_range(16, 2)));
        add_random(300, 25);

        idle_mode = IDLE_SEND_HEAVY;
        load_settings(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), '0);
        add_random(200, 50);
        load_settings(SAMPLE_MAX, SAMPLE_MIN, 24'd1);
        add_random(250, 10);

        idle_mode = IDLE_NONE;
        load_settings(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                      CFG_DATA_W'($urandom_range(255, 1)));
        add_random(450, 10);

        drain_core();
        $display("Checked %0d readings over %0d register settings: depth 0, 1 and 255,",
                 readings_checked, settings_used);
        $display("saturated nets, frozen averages, restarts and saturated sample counts.");
        if (error_count == 0 && expected_readings.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/tra_pkg.sv
design/tra_div.sv
design/tra_ctrl.sv
design/tra_datapath.sv
design/tare_and_running_average_core.sv
design/tra_checker.sv
dv/tare_and_running_average_core_tb.sv
